FILE: hdl/ttcw_pkg.sv
`default_nettype none

package ttcw_pkg;

    // Default geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Character codes
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'h20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 8'd1;

    // Register reset values
    localparam logic [7:0] TEXT_ATTR_RST  = 8'd8;
    localparam logic [7:0] BLANK_ATTR_RST = 8'd7;

    // Cell written by the clearing pass after reset
    localparam logic [15:0] RESET_BLANK = {BLANK_ATTR_RST, CODE_SPACE};

    // Item opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CHAR,
        WR_SCROLL
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ITEM,
        RD_SCROLL
    } rd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_CR,
        CUR_ADV,
        CUR_NEWLINE,
        CUR_HOME_LAST
    } cur_op_t;

    typedef struct packed {
        logic    latch;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        cnt_op_t cnt_op;
        cur_op_t cur_op;
        logic    emit;
        logic    emit_scrolled;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_cr;
        logic is_lf;
        logic col_last;
        logic row_last;
        logic clear_last;
        logic scroll_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/ttcw_ctrl.sv
`default_nettype none

module ttcw_ctrl
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire ttcw_pkg::dp_status_t status,
    output ttcw_pkg::dp_cmd_t         cmd,
    output logic                      busy
);
    import ttcw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd.latch         = 1'b0;
        cmd.wr_sel        = WR_NONE;
        cmd.rd_sel        = RD_NONE;
        cmd.cnt_op        = CNT_HOLD;
        cmd.cur_op        = CUR_HOLD;
        cmd.emit          = 1'b0;
        cmd.emit_scrolled = 1'b0;
        busy              = 1'b1;
        advance           = status.is_lf || status.col_last;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_sel = WR_CLEAR;
                if (status.clear_last)
                begin
                    cmd.cnt_op = CNT_CLR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_op = CNT_INC;
                end
            end

            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (status.is_read)
                begin
                    cmd.rd_sel = RD_ITEM;
                    state_next = ST_READ;
                end
                else if (status.is_cr)
                begin
                    cmd.cur_op = CUR_CR;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (!status.is_lf)
                    begin
                        cmd.wr_sel = WR_CHAR;
                    end
                    if (advance && status.row_last)
                    begin
                        cmd.cur_op = CUR_HOME_LAST;
                        cmd.cnt_op = CNT_CLR;
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        cmd.cur_op = advance ? CUR_NEWLINE : CUR_ADV;
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_READ:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCROLL:
            begin
                cmd.rd_sel = RD_SCROLL;
                cmd.wr_sel = WR_SCROLL;
                if (status.scroll_last)
                begin
                    cmd.cnt_op        = CNT_CLR;
                    cmd.emit          = 1'b1;
                    cmd.emit_scrolled = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_op = CNT_INC;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/ttcw_datapath.sv
`default_nettype none

module ttcw_datapath
#(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttcw_pkg::ROWS_DEF
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire ttcw_pkg::dp_cmd_t            cmd,
    output ttcw_pkg::dp_status_t              status,
    input  wire                               op,
    input  wire  [7:0]                        ch,
    input  wire  [10:0]                       cell_addr,
    input  wire                               cfg_valid,
    input  wire  [ttcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [7:0]                        cfg_data,
    output logic                              done,
    output logic [15:0]                       cell_data,
    output logic [6:0]                        cursor_col,
    output logic [4:0]                        cursor_row,
    output logic                              scrolled
);
    import ttcw_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int COPY_N    = CELLS - COLUMNS;       // cells moved by a scroll
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;  // first cell of bottom row
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);

    // Screen store
    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    // Latched item
    logic        op_reg;
    logic [7:0]  ch_reg;
    logic [10:0] cell_addr_reg;

    // Cursor
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ADDR_W-1:0] caddr_reg, caddr_next;

    // Sweep counter
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Configuration
    logic [7:0] text_attr_reg;
    logic [7:0] blank_attr_reg;

    // Results
    logic        done_reg;
    logic [15:0] data_reg;
    logic        scrolled_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              in_range;
    logic [CNT_W-1:0]  cnt_prev;

    assign in_range = (32'(cell_addr_reg) < CELLS);
    assign cnt_prev = cnt_reg - CNT_W'(1);

    // Write port
    always_comb
    begin
        we    = 1'b0;
        waddr = caddr_reg;
        wdata = {text_attr_reg, ch_reg};
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                we    = 1'b1;
                waddr = ADDR_W'(cnt_reg);
                wdata = RESET_BLANK;
            end
            WR_CHAR:
            begin
                we    = 1'b1;
            end
            WR_SCROLL:
            begin
                // write trails the read: the registered read data goes to the previous count's cell
                we    = (cnt_reg != '0);
                waddr = ADDR_W'(cnt_prev);
                wdata = (32'(cnt_reg) <= COPY_N) ? rdata_reg : {blank_attr_reg, CODE_SPACE};
            end
            default:
            begin
                we    = 1'b0;
            end
        endcase
    end

    // Read port
    always_comb
    begin
        re    = 1'b0;
        raddr = ADDR_W'(32'(cell_addr_reg));
        case (cmd.rd_sel)
            RD_ITEM:
            begin
                re = in_range;
            end
            RD_SCROLL:
            begin
                re    = (32'(cnt_reg) < COPY_N);
                raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg        <= op;
            ch_reg        <= ch;
            cell_addr_reg <= cell_addr;
        end
    end

    // Cursor update
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        caddr_next = caddr_reg;
        case (cmd.cur_op)
            CUR_CR:
            begin
                col_next   = '0;
                caddr_next = caddr_reg - ADDR_W'(col_reg);
            end
            CUR_ADV:
            begin
                col_next   = col_reg + COL_W'(1);
                caddr_next = caddr_reg + ADDR_W'(1);
            end
            CUR_NEWLINE:
            begin
                col_next   = '0;
                row_next   = row_reg + ROW_W'(1);
                caddr_next = caddr_reg - ADDR_W'(col_reg) + ADDR_W'(COLUMNS);
            end
            CUR_HOME_LAST:
            begin
                col_next   = '0;
                row_next   = ROW_W'(ROWS - 1);
                caddr_next = ADDR_W'(LAST_BASE);
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_CLR:  cnt_next = '0;
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            caddr_reg      <= '0;
            cnt_reg        <= '0;
            text_attr_reg  <= TEXT_ATTR_RST;
            blank_attr_reg <= BLANK_ATTR_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            caddr_reg <= caddr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= cmd.emit;
            if (cfg_valid)
            begin
                if (cfg_index == REG_TEXT_ATTR)
                begin
                    text_attr_reg <= cfg_data;
                end
                else if (cfg_index == REG_BLANK_ATTR)
                begin
                    blank_attr_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            data_reg     <= (op_reg == OP_READ && in_range) ? rdata_reg : 16'd0;
            scrolled_reg <= cmd.emit_scrolled;
        end
    end

    always_comb
    begin
        status.is_read     = (op_reg == OP_READ);
        status.is_cr       = (ch_reg == CODE_CR);
        status.is_lf       = (ch_reg == CODE_LF);
        status.col_last    = (col_reg == COL_W'(COLUMNS - 1));
        status.row_last    = (row_reg == ROW_W'(ROWS - 1));
        status.clear_last  = (32'(cnt_reg) == CELLS - 1);
        status.scroll_last = (32'(cnt_reg) == CELLS);
    end

    assign done       = done_reg;
    assign cell_data  = data_reg;
    assign scrolled   = scrolled_reg;
    // cursor registers stay put until the next put is executed
    assign cursor_col = 7'(32'(col_reg));
    assign cursor_row = 5'(32'(row_reg));

endmodule

`default_nettype wire

FILE: hdl/text_terminal_char_writer_unit.sv
// Character-cell text terminal: a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) with a cursor. A transaction is
// taken when start is high and busy is low; each one gives exactly one result,
// shown for a single cycle with done high, and the receiver cannot stall it,
// so capture it on that edge. A put is latched on accept, executed, and done is
// registered from it; a read fetches the cell while executing and gives done
// from an added read state. A put past the bottom row scrolls the screen before
// done, sweeping the single-port-write screen store one cell per cycle. After
// reset the block clears the store to space in the reset blank attribute, one
// cell per cycle, keeping busy high until it ends; configuration writes are
// taken meanwhile. cursor_col and cursor_row hold the cursor until the next put.
// Write the attribute registers only while the block is idle.
`default_nettype none

module text_terminal_char_writer_unit
#(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttcw_pkg::ROWS_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    // item channel
    input  wire                            start,
    output logic                           busy,
    input  wire                            op,
    input  wire  [7:0]                     ch,
    input  wire  [10:0]                    cell_addr,
    // result strobe and payload
    output logic                           done,
    output logic [15:0]                    cell_data,
    output logic [6:0]                     cursor_col,
    output logic [4:0]                     cursor_row,
    output logic                           scrolled,
    // configuration write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [ttcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]                     cfg_data
);
    import ttcw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always accepted, so the channel never waits.
    assign cfg_ready = 1'b1;

    // Sequencer: clearing pass, item execution, scroll sweep
    ttcw_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Screen store, cursor, attribute registers and result registers
    ttcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op         (op),
        .ch         (ch),
        .cell_addr  (cell_addr),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .cell_data  (cell_data),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .scrolled   (scrolled)
    );

endmodule

`default_nettype wire
